// ===== rtl/random_access_slot_reservation_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Slot reservation table assertion macros
// Concurrent assertion helpers, clocked on clk_i by default and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RANDOM_ACCESS_SLOT_RESERVATION_TABLE_UNIT_ASSERT_SVH
`define RANDOM_ACCESS_SLOT_RESERVATION_TABLE_UNIT_ASSERT_SVH

// generic clocked assertion with explicit clock and reset
`define RASRT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// assertion on the default clock and reset names
`define RASRT_ASSERT(lbl, prop, msg) \
  `RASRT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/rasrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot reservation table package
// Field widths, opcodes, controller states and command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rasrt_pkg;

  localparam int unsigned SlotCountW  = 7;
  localparam int unsigned SuperframeW = 32;
  localparam int unsigned ChannelW    = 2;
  localparam int unsigned SlotW       = 6;

  localparam logic [SlotCountW-1:0] SlotCountRst = 7'd64;

  typedef enum logic {
    OP_RESERVE = 1'b0,
    OP_FIND    = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  typedef struct packed {
    logic latch;
    logic lookup;
    logic scan;
  } cmd_t;

endpackage

// ===== rtl/rasrt_req_if.sv =====
// ----------------------------------------------------------------------------
// Slot reservation request channel
// Valid/ready channel carrying one reservation request item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rasrt_req_if;
  import rasrt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [SuperframeW-1:0] superframe;
  logic [ChannelW-1:0]    channel;
  logic [SlotW-1:0]       slot;

  modport source (output valid, opcode, superframe, channel, slot, input ready);
  modport sink   (input valid, opcode, superframe, channel, slot, output ready);

endinterface

// ===== rtl/rasrt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Slot reservation response channel
// Valid/ready channel carrying one reservation result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rasrt_rsp_if;
  import rasrt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic [SlotCountW-1:0] slot_index;
  logic                  table_full;

  modport source (output valid, granted, slot_index, table_full, input ready);
  modport sink   (input valid, granted, slot_index, table_full, output ready);

endinterface

// ===== rtl/rasrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot reservation table controller
// One-hot sequencer: accept, tag lookup, slot scan, result hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rasrt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output rasrt_pkg::cmd_t cmd_o
);
  import rasrt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rasrt_dp.sv =====
// ----------------------------------------------------------------------------
// Slot reservation table datapath
// Entry table, drop of past superframes, tag match, free-slot scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rasrt_dp #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned MAX_SLOTS     = 64,
  parameter int unsigned CHANNELS      = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rasrt_pkg::cmd_t                  cmd_i,
  input  logic                             cfg_we_i,
  input  logic [rasrt_pkg::SlotCountW-1:0] cfg_wdata_i,
  input  logic                             opcode_i,
  input  logic [rasrt_pkg::SuperframeW-1:0] superframe_i,
  input  logic [rasrt_pkg::ChannelW-1:0]   channel_i,
  input  logic [rasrt_pkg::SlotW-1:0]      slot_i,
  output logic                             granted_o,
  output logic [rasrt_pkg::SlotCountW-1:0] slot_index_o,
  output logic                             table_full_o
);
  import rasrt_pkg::*;

  localparam int unsigned EntryW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SlotIdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [SlotCountW-1:0] MaxSlotsC = SlotCountW'(MAX_SLOTS);

  logic [SlotCountW-1:0]  slot_count_q;
  logic                   opcode_q;
  logic [SuperframeW-1:0] sf_q;
  logic [ChannelW-1:0]    ch_q;
  logic [SlotW-1:0]       slot_q;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [SuperframeW-1:0]   entry_sf_q   [TABLE_ENTRIES];
  logic [ChannelW-1:0]      entry_ch_q   [TABLE_ENTRIES];
  logic [MAX_SLOTS-1:0]     entry_used_q [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] keep;
  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit_d, free_found_d;
  logic [EntryW-1:0]        hit_idx_d, free_idx_d;

  logic                 hit_q, free_found_q;
  logic [EntryW-1:0]    hit_idx_q, free_idx_q;
  logic [MAX_SLOTS-1:0] used_q;

  logic [SlotCountW-1:0] count_eff;
  logic [SlotCountW-1:0] start;
  logic                  chan_ok, slot_ok, used_bit;
  logic                  f_found;
  logic [SlotCountW-1:0] f_idx;
  logic [SlotCountW-1:0] cand;
  logic                  have_cand, grant, full;
  logic [SlotCountW-1:0] idx;
  logic [MAX_SLOTS-1:0]  cand_mask;

  logic                  granted_q, table_full_q;
  logic [SlotCountW-1:0] slot_index_q;

  // configuration and request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountRst;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      opcode_q <= opcode_i;
      sf_q     <= superframe_i;
      ch_q     <= channel_i;
      slot_q   <= slot_i;
    end
  end

  // lookup: drop past superframes, match key, pick lowest free entry
  always_comb begin
    hit_d        = 1'b0;
    hit_idx_d    = '0;
    free_found_d = 1'b0;
    free_idx_d   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      keep[i]  = valid_q[i] && !(entry_sf_q[i] < sf_q);
      match[i] = keep[i] && (entry_sf_q[i] == sf_q) && (entry_ch_q[i] == ch_q);
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_d     = 1'b1;
        hit_idx_d = EntryW'(i);
      end
      if (!keep[i]) begin
        free_found_d = 1'b1;
        free_idx_d   = EntryW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q        <= hit_d;
      hit_idx_q    <= hit_idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      used_q       <= hit_d ? entry_used_q[hit_idx_d] : '0;
    end
  end

  // scan: test or search the used bitmap
  always_comb begin
    count_eff = (slot_count_q > MaxSlotsC) ? MaxSlotsC : slot_count_q;
    start     = {1'b0, slot_q};
    chan_ok   = int'(ch_q) < CHANNELS;
    slot_ok   = start < MaxSlotsC;
    used_bit  = used_q[slot_q[SlotIdxW-1:0]];
    f_found   = 1'b0;
    f_idx     = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (!used_q[s] && (SlotCountW'(s) >= start) && (SlotCountW'(s) < count_eff)) begin
        f_found = 1'b1;
        f_idx   = SlotCountW'(s);
      end
    end
    if (opcode_q == OP_FIND) begin
      cand      = f_idx;
      have_cand = chan_ok && f_found;
    end else begin
      cand      = start;
      have_cand = chan_ok && slot_ok && (!hit_q || !used_bit);
    end
    grant     = have_cand && (hit_q || free_found_q);
    full      = have_cand && !hit_q && !free_found_q;
    cand_mask = MAX_SLOTS'(1) << cand;
    if (grant) begin
      idx = cand;
    end else if (opcode_q == OP_FIND) begin
      idx = count_eff;
    end else begin
      idx = start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.lookup) begin
      valid_q <= keep;
    end else if (cmd_i.scan && grant && !hit_q) begin
      valid_q[free_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && grant) begin
      if (hit_q) begin
        entry_used_q[hit_idx_q] <= used_q | cand_mask;
      end else begin
        entry_sf_q[free_idx_q]   <= sf_q;
        entry_ch_q[free_idx_q]   <= ch_q;
        entry_used_q[free_idx_q] <= cand_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      granted_q    <= grant;
      slot_index_q <= idx;
      table_full_q <= full;
    end
  end

  assign granted_o    = granted_q;
  assign slot_index_o = slot_index_q;
  assign table_full_o = table_full_q;

endmodule

// ===== rtl/random_access_slot_reservation_table_unit.sv =====
// ----------------------------------------------------------------------------
// Random access slot reservation table
// Tracks used random access slots per superframe and channel.
// Sequence: an accepted request passes the lookup and scan steps one after
//   the other in the shared datapath; the result is then valid, held until
//   taken. No new request is accepted until the result has been taken.
// Reset: table empty, slot_count 64, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module random_access_slot_reservation_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 8,
  parameter int unsigned MAX_SLOTS     = 64,
  parameter int unsigned CHANNELS      = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rasrt_pkg::SlotCountW-1:0] cfg_wdata_i,
  rasrt_req_if.sink                        req_i,
  rasrt_rsp_if.source                      rsp_o
);
  import rasrt_pkg::*;

  cmd_t cmd;

  rasrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .cmd_o      (cmd)
  );

  rasrt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_SLOTS    (MAX_SLOTS),
    .CHANNELS     (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (req_i.opcode),
    .superframe_i(req_i.superframe),
    .channel_i   (req_i.channel),
    .slot_i      (req_i.slot),
    .granted_o   (rsp_o.granted),
    .slot_index_o(rsp_o.slot_index),
    .table_full_o(rsp_o.table_full)
  );

endmodule

// ===== rtl/rasrt_checker.sv =====
// ----------------------------------------------------------------------------
// Slot reservation table port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "random_access_slot_reservation_table_unit_assert.svh"

module rasrt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             rsp_valid_i,
  input logic                             rsp_ready_i,
  input logic                             granted_i,
  input logic [rasrt_pkg::SlotCountW-1:0] slot_index_i,
  input logic                             table_full_i
);

  `RASRT_ASSERT(a_rsp_hold, (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i, "result item dropped")
  `RASRT_ASSERT(a_busy_after_accept, (req_valid_i && req_ready_i) |=> !req_ready_i, "accept while busy")
  `RASRT_ASSERT(a_no_accept_on_rsp, rsp_valid_i |-> !req_ready_i, "accept while result pending")
  `RASRT_ASSERT(a_full_not_granted, (rsp_valid_i && table_full_i) |-> !granted_i, "grant with full table")
  `RASRT_ASSERT(a_index_range, rsp_valid_i |-> (slot_index_i <= 7'd64), "slot index out of range")

endmodule

bind random_access_slot_reservation_table_unit rasrt_checker u_rasrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .granted_i   (rsp_o.granted),
  .slot_index_i(rsp_o.slot_index),
  .table_full_i(rsp_o.table_full)
);
